>>> rtl/ivf_pkg.sv
// Shared types and constants for the IVF container demuxer.
package ivf_pkg;

   typedef enum logic [2:0] {
      KIND_INFO    = 3'd0,
      KIND_LAYER   = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_END_OK  = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ERR_SIGNATURE  = 4'd0,
      ERR_CODEC      = 4'd1,
      ERR_ZERO_DIM   = 4'd2,
      ERR_ZERO_SCALE = 4'd3,
      ERR_ZERO_COUNT = 4'd4,
      ERR_NO_FRAME   = 4'd5,
      ERR_ZERO_LAYER = 4'd6,
      ERR_NEG_TS     = 4'd7,
      ERR_TRUNCATED  = 4'd8,
      ERR_MISMATCH   = 4'd9
   } err_type;

   typedef enum logic [2:0] {
      ST_FILE, ST_FRAME, ST_PAYLOAD, ST_DIVIDE, ST_OUTPUT, ST_DONE, ST_ERROR
   } state_type;

   localparam logic [31:0] TAG_DKIF = 32'h46494B44;
   localparam logic [31:0] TAG_VP80 = 32'h30385056;
   localparam logic [31:0] TAG_VP90 = 32'h30395056;
   localparam logic [31:0] TAG_AV01 = 32'h31305641;
   localparam logic [31:0] TAG_H264 = 32'h34363248;
   localparam logic [31:0] TAG_H265 = 32'h35363248;
   localparam logic [16:0] RTP_CLOCK_HZ = 17'd90000;

   localparam logic [4:0] POS_SIG   = 5'd3;
   localparam logic [4:0] POS_CODEC = 5'd11;
   localparam logic [4:0] POS_DIM   = 5'd15;
   localparam logic [4:0] POS_SCALE = 5'd19;
   localparam logic [4:0] POS_COUNT = 5'd27;
   localparam logic [4:0] POS_FHEND = 5'd31;
   localparam logic [4:0] POS_SIZE  = 5'd3;
   localparam logic [4:0] POS_TSEND = 5'd11;

   // Commands from controller to datapath
   typedef struct packed {
      logic       shift_byte;   // take byte into header shift
      logic       pos_inc;
      logic       pos_clear;
      logic       load_codec;
      logic       load_dim;
      logic       load_scale;
      logic       load_count;
      logic       load_size;
      logic       frame_accept; // update layer tracking, frames_seen
      logic       payload_dec;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      kind_type   out_kind;
      err_type    out_err;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [4:0] pos;
      logic       sig_bad;     // on incoming byte
      logic       codec_bad;
      logic       dim_bad;
      logic       scale_bad;
      logic       count_bad;
      logic       size_zero;
      logic       ts_neg;
      logic       payload_last;
      logic       no_frames;
      logic       count_match;
      logic       div_done;
   } sts_type;

endpackage

>>> rtl/ivf_ctrl.sv
// Controller state machine for the IVF container demuxer.
module ivf_ctrl import ivf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_end_of_file,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      acc;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && (state_ff == ST_FILE || state_ff == ST_FRAME ||
                      state_ff == ST_PAYLOAD || state_ff == ST_DONE || state_ff == ST_ERROR);
   assign acc       = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      if (acc && !(state_ff == ST_DONE || state_ff == ST_ERROR)) begin
         if (req_end_of_file) begin
            if (state_ff == ST_FRAME && sts.pos == 5'd0)
               state_in = (sts.no_frames || !sts.count_match) ? ST_ERROR : ST_DONE;
            else
               state_in = ST_ERROR;
         end else begin
            unique case (state_ff)
               ST_FILE: begin
                  priority if ((sts.pos == POS_SIG && sts.sig_bad) ||
                               (sts.pos == POS_CODEC && sts.codec_bad) ||
                               (sts.pos == POS_DIM && sts.dim_bad) ||
                               (sts.pos == POS_SCALE && sts.scale_bad) ||
                               (sts.pos == POS_COUNT && sts.count_bad))
                     state_in = ST_ERROR;
                  else if (sts.pos == POS_FHEND)
                     state_in = ST_FRAME;
                  else
                     state_in = ST_FILE;
               end
               ST_FRAME: begin
                  if (sts.pos == POS_TSEND)
                     state_in = (sts.size_zero || sts.ts_neg) ? ST_ERROR : ST_DIVIDE;
               end
               ST_PAYLOAD: if (sts.payload_last) state_in = ST_FRAME;
               default: ;
            endcase
         end
      end else if (state_ff == ST_DIVIDE && sts.div_done) begin
         state_in = ST_OUTPUT;
      end else if (state_ff == ST_OUTPUT && out_free) begin
         state_in = ST_PAYLOAD;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.out_kind = KIND_INFO;
      cmd.out_err  = ERR_SIGNATURE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (acc && !(state_ff == ST_DONE || state_ff == ST_ERROR)) begin
         if (req_end_of_file) begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            if (state_ff == ST_FRAME && sts.pos == 5'd0) begin
               if (sts.no_frames) begin
                  cmd.out_kind = KIND_ERROR; cmd.out_err = ERR_NO_FRAME;
               end else if (!sts.count_match) begin
                  cmd.out_kind = KIND_ERROR; cmd.out_err = ERR_MISMATCH;
               end else
                  cmd.out_kind = KIND_END_OK;
            end else begin
               cmd.out_kind = KIND_ERROR; cmd.out_err = ERR_TRUNCATED;
            end
         end else begin
            unique case (state_ff)
               ST_FILE: begin
                  cmd.shift_byte = 1'b1;
                  cmd.pos_inc    = 1'b1;
                  cmd.out_kind   = KIND_ERROR;
                  priority if (sts.pos == POS_SIG && sts.sig_bad) begin
                     cmd.out_err = ERR_SIGNATURE;
                  end else if (sts.pos == POS_CODEC && sts.codec_bad) begin
                     cmd.out_err = ERR_CODEC;
                  end else if (sts.pos == POS_DIM && sts.dim_bad) begin
                     cmd.out_err = ERR_ZERO_DIM;
                  end else if (sts.pos == POS_SCALE && sts.scale_bad) begin
                     cmd.out_err = ERR_ZERO_SCALE;
                     cmd.load_scale = 1'b1;
                  end else if (sts.pos == POS_COUNT && sts.count_bad) begin
                     cmd.out_err = ERR_ZERO_COUNT;
                  end else begin
                     cmd.out_kind   = KIND_INFO;
                     cmd.load_codec = (sts.pos == POS_CODEC);
                     cmd.load_dim   = (sts.pos == POS_DIM);
                     cmd.load_scale = (sts.pos == POS_SCALE);
                     cmd.load_count = (sts.pos == POS_COUNT);
                     if (sts.pos == POS_FHEND) begin
                        cmd.pos_inc   = 1'b0;
                        cmd.pos_clear = 1'b1;
                     end
                  end
                  if (state_in == ST_ERROR || sts.pos == POS_FHEND) begin
                     cmd.out_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end
               ST_FRAME: begin
                  cmd.shift_byte = 1'b1;
                  cmd.pos_inc    = 1'b1;
                  cmd.load_size  = (sts.pos == POS_SIZE);
                  if (sts.pos == POS_TSEND) begin
                     cmd.pos_inc = 1'b0;
                     cmd.pos_clear = 1'b1;
                     if (sts.size_zero || sts.ts_neg) begin
                        cmd.out_load = 1'b1;
                        rsp_valid_in = 1'b1;
                        cmd.out_kind = KIND_ERROR;
                        cmd.out_err  = sts.size_zero ? ERR_ZERO_LAYER : ERR_NEG_TS;
                     end else begin
                        cmd.frame_accept = 1'b1;
                        cmd.div_start    = 1'b1;
                     end
                  end
               end
               ST_PAYLOAD: begin
                  cmd.payload_dec = 1'b1;
                  cmd.out_load    = 1'b1;
                  cmd.out_kind    = KIND_PAYLOAD;
                  rsp_valid_in    = 1'b1;
               end
               default: ;
            endcase
         end
      end else if (state_ff == ST_DIVIDE) begin
         cmd.div_step = 1'b1;
      end else if (state_ff == ST_OUTPUT && out_free) begin
         cmd.out_load = 1'b1;
         cmd.out_kind = KIND_LAYER;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ivf_dpath.sv
// Datapath for the IVF container demuxer: header fields, counters, divider, result register.
module ivf_dpath import ivf_pkg::*; #(
   parameter int MAX_LAYERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_codec,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height,
   output logic [31:0] rsp_layer_size,
   output logic [62:0] rsp_timestamp,
   output logic [31:0] rsp_rtp_timestamp,
   output logic [2:0]  rsp_layer_index,
   output logic        rsp_key_frame,
   output logic [3:0]  rsp_error_code
);

   localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam logic [LW:0] LMAX = (LW + 1)'(MAX_LAYERS - 1);

   logic [4:0]  pos_ff;
   logic [63:0] shift_ff;
   logic [31:0] scale_ff, expect_ff, seen_ff, left_ff;
   logic [63:0] prev_ff;
   logic [LW:0] layer_ff, layer_in;
   logic        first_ff, first_in;
   logic [2:0]  codec_ff;
   logic [2:0]  codec_in;
   logic [15:0] width_ff, height_ff;
   logic [63:0] shift_in;
   logic [31:0] top_in;
   logic        codec_hit;

   // divider: 81-bit dividend (64b ts * 17b const), restoring, one bit per cycle
   logic [80:0] dvd_ff;
   logic [31:0] rem_ff;
   logic [31:0] quo_ff;
   logic [6:0]  cnt_ff;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;

   assign shift_in = {req_data_byte, shift_ff[63:8]};
   assign top_in   = shift_in[63:32];

   always_comb begin
      codec_hit = 1'b1;
      codec_in  = 3'd0;
      unique case (top_in)
         TAG_VP80: codec_in = 3'd0;
         TAG_VP90: codec_in = 3'd1;
         TAG_AV01: codec_in = 3'd2;
         TAG_H264: codec_in = 3'd3;
         TAG_H265: codec_in = 3'd4;
         default:  codec_hit = 1'b0;
      endcase
   end

   always_comb begin
      layer_in = layer_ff;
      first_in = first_ff;
      if (seen_ff == 32'd0) begin
         layer_in = '0;
         first_in = 1'b1;
      end else if (shift_in == prev_ff) begin
         if (layer_ff < LMAX) layer_in = layer_ff + 1'b1;
      end else begin
         layer_in = '0;
         first_in = 1'b0;
      end
   end

   assign sts.pos          = pos_ff;
   assign sts.sig_bad      = top_in != TAG_DKIF;
   assign sts.codec_bad    = !codec_hit;
   assign sts.dim_bad      = (top_in[15:0] == 16'd0) || (top_in[31:16] == 16'd0);
   assign sts.scale_bad    = top_in == 32'd0;
   assign sts.count_bad    = top_in == 32'd0;
   assign sts.size_zero    = left_ff == 32'd0;
   assign sts.ts_neg       = req_data_byte[7];
   assign sts.payload_last = left_ff == 32'd1;
   assign sts.no_frames    = seen_ff == 32'd0;
   assign sts.count_match  = seen_ff == expect_ff;
   assign sts.div_done     = cnt_ff == 7'd0;

   assign rem_sh  = {rem_ff, dvd_ff[80]};
   assign rem_sub = rem_sh - {1'b0, scale_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         shift_ff  <= '0;
         scale_ff  <= '0;
         expect_ff <= '0;
         seen_ff   <= '0;
         left_ff   <= '0;
         prev_ff   <= '0;
         layer_ff  <= '0;
         first_ff  <= 1'b1;
         codec_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.shift_byte) shift_ff <= shift_in;
         if (cmd.pos_clear) pos_ff <= '0;
         else if (cmd.pos_inc) pos_ff <= pos_ff + 5'd1;
         if (cmd.load_codec) codec_ff <= codec_in;
         if (cmd.load_dim) begin
            width_ff  <= top_in[15:0];
            height_ff <= top_in[31:16];
         end
         if (cmd.load_scale) scale_ff <= top_in;
         if (cmd.load_count) expect_ff <= top_in;
         if (cmd.load_size) left_ff <= top_in;
         else if (cmd.payload_dec) left_ff <= left_ff - 32'd1;
         if (cmd.frame_accept) begin
            layer_ff <= layer_in;
            first_ff <= first_in;
            prev_ff  <= shift_in;
            seen_ff  <= seen_ff + 32'd1;
         end
         if (cmd.div_start) cnt_ff <= 7'd81;
         else if (cmd.div_step && cnt_ff != 7'd0) cnt_ff <= cnt_ff - 7'd1;
      end
   end

   // quotient low 32 bits; remainder < scale fits 32 bits, shifted trial needs 33
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= 81'(shift_in) * 81'(RTP_CLOCK_HZ);
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step && cnt_ff != 7'd0) begin
         dvd_ff <= {dvd_ff[79:0], 1'b0};
         if (scale_ff != 32'd0 && !rem_sub[32]) begin
            rem_ff <= rem_sub[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind          <= cmd.out_kind;
         rsp_payload_byte  <= '0;
         rsp_codec         <= '0;
         rsp_frame_width   <= '0;
         rsp_frame_height  <= '0;
         rsp_layer_size    <= '0;
         rsp_timestamp     <= '0;
         rsp_rtp_timestamp <= '0;
         rsp_layer_index   <= '0;
         rsp_key_frame     <= 1'b0;
         rsp_error_code    <= '0;
         unique case (cmd.out_kind)
            KIND_INFO: begin
               rsp_codec        <= codec_ff;
               rsp_frame_width  <= width_ff;
               rsp_frame_height <= height_ff;
            end
            KIND_LAYER: begin
               rsp_layer_size    <= left_ff;
               rsp_timestamp     <= prev_ff[62:0];
               rsp_rtp_timestamp <= (scale_ff == 32'd0) ? 32'd0 : quo_ff;
               rsp_layer_index   <= 3'(layer_ff);
               rsp_key_frame     <= first_ff;
            end
            KIND_PAYLOAD: rsp_payload_byte <= req_data_byte;
            KIND_ERROR:   rsp_error_code   <= cmd.out_err;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/ivf_container_demuxer_unit.sv
// Top level of the IVF container demuxer: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_ready   | data_byte, end_of_file
//  rsp_    | out       | rsp_valid/rsp_ready   | kind and descriptor fields
//
// Header, payload and end-of-file bytes are accepted while the result register
// is free. After a frame header the input is held off for the bit-serial
// rescale divide (81 steps, then a check that the count has run out) and for
// the layer descriptor, which waits for the result register to be free.
// Reset is synchronous, active high; it restarts parsing at the file header.
// A stalled result holds the input off; inputs after end or error are dropped.
module ivf_container_demuxer_unit import ivf_pkg::*; #(
   parameter int MAX_LAYERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_codec,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height,
   output logic [31:0] rsp_layer_size,
   output logic [62:0] rsp_timestamp,
   output logic [31:0] rsp_rtp_timestamp,
   output logic [2:0]  rsp_layer_index,
   output logic        rsp_key_frame,
   output logic [3:0]  rsp_error_code
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: header/payload phases, divide wait, result hand-off
   ivf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_end_of_file,
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   // fields, counters, rescale divider and result register
   ivf_dpath #(.MAX_LAYERS(MAX_LAYERS)) u_dpath (
      .clock, .reset, .req_data_byte, .cmd, .sts,
      .rsp_kind, .rsp_payload_byte, .rsp_codec, .rsp_frame_width,
      .rsp_frame_height, .rsp_layer_size, .rsp_timestamp, .rsp_rtp_timestamp,
      .rsp_layer_index, .rsp_key_frame, .rsp_error_code
   );

endmodule
